// File: src/reliable_stream_reassembly_assert.svh
// Assertion macros shared by the reassembly receiver.
`ifndef RELIABLE_STREAM_REASSEMBLY_ASSERT_SVH
`define RELIABLE_STREAM_REASSEMBLY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/rsr_pkg.sv
// Shared types, codes and defaults of the stream reassembly receiver.
`default_nettype none
package rsr_pkg;

    localparam int unsigned RING_BYTES_DEF  = 65536;
    localparam int unsigned SLOT_COUNT_DEF  = 64;
    localparam int unsigned MAX_PAYLOAD_DEF = 1000;
    localparam int unsigned READ_MAX_DEF    = 32;

    localparam logic [7:0]  SEG_MAGIC     = 8'h45;
    localparam int unsigned FLAG_DATA_BIT = 0;
    localparam logic [31:0] TIMEOUT_RESET = 32'd200;
    localparam logic [31:0] RETRY_RESET   = 32'd100;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_W     = 2;

    typedef enum logic [1:0] {
        OP_HEADER  = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_TICK    = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_READ   = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_TIMEOUT = 1'b0,
        CFG_RETRY   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CP_INORDER,
        CP_PARK,
        CP_MERGE
    } t_copy;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIN,
        S_OLD_ACK,
        S_TIMER,
        S_EMPTY,
        S_READ_RD,
        S_READ_EMIT,
        S_ACK_CHK,
        S_MERGE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_COPY
    } t_bstate;

    // Classified input word handed from front to back
    typedef struct packed {
        t_op         op;
        logic        hdr_ok;
        logic [15:0] seg_length;
        logic [31:0] seg_seq;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic [5:0]  read_n;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] control_seq;
        logic [7:0]  read_byte;
        logic        read_last;
    } t_result;

endpackage
`default_nettype wire

// File: src/reliable_stream_reassembly.sv
// Flow: a word waits in a 4-deep queue. In the engine a header or a payload byte is handled
// in the idle state, a tick also in the timer state, and a read drains the ring byte by byte
// through a read state and an emit state (single ring read port), then walks the slot table.
// A completed in-order segment is judged, copied byte by byte, acked and followed by a slot
// walk; each merged slot repeats copy and walk. Result stalls hold the engine, then the queue.
// Reset: synchronous, active low; timeout 200, retry 100, counters and slot valid bits cleared.
`default_nettype none
`include "reliable_stream_reassembly_assert.svh"
module reliable_stream_reassembly import rsr_pkg::*; #(
    parameter int unsigned RING_BYTES  = RING_BYTES_DEF,
    parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int unsigned READ_MAX    = READ_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // magic[7:0], seg_flags[15:8], seg_length[31:16], seg_seq[63:32],
    // payload_byte[71:64], read_limit[77:72], zero[79:78]
    input  wire logic [79:0] i_s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // control_seq[31:0], read_byte[39:32]
    output logic [39:0]      o_m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]       o_m_axis_tuser,
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic [31:0] r_tmo, r_retry;
    logic        item_valid, item_ready;
    t_item       item;
    t_result     res;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo   <= TIMEOUT_RESET;
            r_retry <= RETRY_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIMEOUT: r_tmo   <= i_cfg_data;
                CFG_RETRY:   r_retry <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rsr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .READ_MAX    (READ_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_item_valid    (item_valid),
        .i_item_ready    (item_ready),
        .o_item          (item)
    );

    rsr_back #(
        .RING_BYTES  (RING_BYTES),
        .SLOT_COUNT  (SLOT_COUNT),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_timeout    (r_tmo),
        .i_retry      (r_retry),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res        (res)
    );

    // Pack the result word
    assign o_m_axis_tdata = {res.read_byte, res.control_seq};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.read_last;

    `RSR_ASSERT_NEXT(a_cfg_timeout, i_clk, i_rst_n,
        i_cfg_valid && (i_cfg_index == CFG_TIMEOUT), r_tmo == $past(i_cfg_data),
        "timeout register did not take the written value")
    `RSR_ASSERT_IMPL(a_last_on_read, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tuser == KIND_READ,
        "read_last set on a result that is not a read byte")
    `RSR_ASSERT_IMPL(a_read_no_seq, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_READ || o_m_axis_tuser == KIND_EMPTY),
        o_m_axis_tdata[31:0] == 32'd0,
        "read result carries a sequence number")

endmodule
`default_nettype wire

// File: src/rsr_front.sv
// Input side: accepts words, classifies them and queues them for the engine.
`default_nettype none
module rsr_front import rsr_pkg::*; #(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int unsigned READ_MAX    = READ_MAX_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [79:0] i_s_axis_tdata,
    input  wire logic [1:0]  i_s_axis_tuser,
    input  wire logic        i_s_axis_tlast,
    output logic             o_item_valid,
    input  wire logic        i_item_ready,
    output t_item            o_item
);

    t_item               r_queue [QUEUE_DEPTH];
    logic [QUEUE_W-1:0]  r_wptr, r_rptr;
    logic [QUEUE_W:0]    r_count;
    t_item               cls;
    logic                push, pop;
    logic [7:0]          magic, flags;
    logic [15:0]         len;
    logic [5:0]          limit;

    assign magic = i_s_axis_tdata[7:0];
    assign flags = i_s_axis_tdata[15:8];
    assign len   = i_s_axis_tdata[31:16];
    assign limit = i_s_axis_tdata[77:72];

    // Classify the incoming word
    always_comb begin
        cls.op           = t_op'(i_s_axis_tuser);
        cls.hdr_ok       = (magic == SEG_MAGIC) && flags[FLAG_DATA_BIT] && (len != 16'd0)
                           && (32'(len) <= 32'(MAX_PAYLOAD));
        cls.seg_length   = len;
        cls.seg_seq      = i_s_axis_tdata[63:32];
        cls.payload_byte = i_s_axis_tdata[71:64];
        cls.payload_last = i_s_axis_tlast;
        cls.read_n       = (32'(limit) > 32'(READ_MAX)) ? 6'(READ_MAX) : limit;
    end

    assign o_s_axis_tready = (r_count != (QUEUE_W+1)'(QUEUE_DEPTH));
    assign o_item_valid    = (r_count != '0);
    assign o_item          = r_queue[r_rptr];
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = o_item_valid && i_item_ready;

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wptr <= r_wptr + 1'b1;
            if (pop)  r_rptr <= r_rptr + 1'b1;
            if (push && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !push) r_count <= r_count - 1'b1;
        end
    end

    // Store the classified word
    always_ff @(posedge i_clk) begin
        if (push) r_queue[r_wptr] <= cls;
    end

endmodule
`default_nettype wire

// File: src/rsr_back.sv
// Engine: segment staging, ring, out-of-order slots, merge walk, timer and reads.
`default_nettype none
module rsr_back import rsr_pkg::*; #(
    parameter int unsigned RING_BYTES  = RING_BYTES_DEF,
    parameter int unsigned SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_timeout,
    input  wire logic [31:0] i_retry,
    input  wire logic        i_item_valid,
    output logic             o_item_ready,
    input  wire t_item       i_item,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output t_result          o_res
);

    localparam int unsigned PTR_W  = $clog2(RING_BYTES);
    localparam int unsigned FILL_W = $clog2(RING_BYTES + 1);
    localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);
    localparam int unsigned OFF_W  = $clog2(MAX_PAYLOAD);
    localparam int unsigned LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned SBYTES = SLOT_COUNT << OFF_W;

    // Memories
    logic [7:0]       r_ring_mem  [RING_BYTES];
    logic [7:0]       r_stage_mem [MAX_PAYLOAD];
    logic [7:0]       r_slot_mem  [SBYTES];
    logic [31:0]      r_seq_mem   [SLOT_COUNT];
    logic [LEN_W-1:0] r_len_mem   [SLOT_COUNT];
    logic [7:0]       r_ring_q, r_stage_q, r_slot_q;
    logic [31:0]      r_seq_q;
    logic [LEN_W-1:0] r_len_q;

    // Control and state registers
    t_bstate           r_state, n_state;
    logic              r_open, n_open, r_sc_ok, n_sc_ok;
    logic [15:0]       r_sc_len, n_sc_len, r_sc_cnt, n_sc_cnt;
    logic [31:0]       r_sc_seq, n_sc_seq;
    logic [PTR_W-1:0]  r_head, n_head, r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [31:0]       r_exp, n_exp, r_high, n_high, r_acked, n_acked;
    logic [31:0]       r_prog, n_prog, r_rtime, n_rtime, r_rseq, n_rseq, r_tick, n_tick;
    logic              r_active, n_active;
    logic [SLOT_W-1:0] r_idx, n_idx, r_free, n_free;
    logic              r_free_ok, n_free_ok, r_moved, n_moved, r_scan_park, n_scan_park;
    logic              r_after_merge, n_after_merge;
    t_copy             r_copy, n_copy;
    logic [LEN_W-1:0]  r_cp_len, n_cp_len, r_rd_cnt, n_rd_cnt, r_wr_cnt, n_wr_cnt;
    logic              r_pv, n_pv;
    logic [5:0]        r_rd_n, n_rd_n, r_rd_i, n_rd_i;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    // Memory strobes
    logic              ring_we, ring_re, stage_we, stage_re, slot_we, slot_re, meta_we, meta_re;
    logic [7:0]        wdata;
    logic [31:0]       end_seq, key;
    logic [FILL_W-1:0] ring_free;
    logic [PTR_W-1:0]  head_inc, tail_inc;
    logic              out_free, hit, rd_go, cp_done, timer_fire, last_slot;

    assign ring_free = FILL_W'(RING_BYTES) - r_fill;
    assign head_inc  = (r_head == PTR_W'(RING_BYTES - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc  = (r_tail == PTR_W'(RING_BYTES - 1)) ? '0 : r_tail + 1'b1;
    assign out_free  = !r_out_valid || i_res_ready;
    assign end_seq   = r_sc_seq + 32'(r_sc_len);
    assign key       = r_scan_park ? r_sc_seq : r_exp;
    assign hit       = r_valid[r_idx] && (r_seq_q == key);
    assign last_slot = (r_idx == SLOT_W'(SLOT_COUNT - 1));
    assign rd_go     = (r_rd_cnt < r_cp_len);
    assign cp_done   = r_pv && ((r_wr_cnt + LEN_W'(1)) == r_cp_len);
    assign wdata     = (r_copy == CP_MERGE) ? r_slot_q : r_stage_q;
    assign timer_fire = r_active && (r_high > r_exp) && ((r_tick - r_prog) >= i_timeout)
                        && !((r_rseq == r_exp) && ((r_tick - r_rtime) < i_retry));

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;

    // Next state and datapath control
    always_comb begin
        n_state = r_state;     n_open = r_open;       n_sc_ok = r_sc_ok;
        n_sc_len = r_sc_len;   n_sc_cnt = r_sc_cnt;   n_sc_seq = r_sc_seq;
        n_head = r_head;       n_tail = r_tail;       n_fill = r_fill;
        n_valid = r_valid;     n_exp = r_exp;         n_high = r_high;
        n_acked = r_acked;     n_prog = r_prog;       n_rtime = r_rtime;
        n_rseq = r_rseq;       n_tick = r_tick;       n_active = r_active;
        n_idx = r_idx;         n_free = r_free;       n_free_ok = r_free_ok;
        n_moved = r_moved;     n_scan_park = r_scan_park;
        n_after_merge = r_after_merge;
        n_copy = r_copy;       n_cp_len = r_cp_len;   n_rd_cnt = r_rd_cnt;
        n_wr_cnt = r_wr_cnt;   n_pv = 1'b0;           n_rd_n = r_rd_n;
        n_rd_i = r_rd_i;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out = r_out;
        ring_we = 1'b0; ring_re = 1'b0; stage_we = 1'b0; stage_re = 1'b0;
        slot_we = 1'b0; slot_re = 1'b0; meta_we = 1'b0;  meta_re = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    unique case (i_item.op)
                        OP_HEADER: begin
                            n_open   = 1'b1;
                            n_sc_ok  = i_item.hdr_ok;
                            n_sc_len = i_item.seg_length;
                            n_sc_seq = i_item.seg_seq;
                            n_sc_cnt = '0;
                        end
                        OP_PAYLOAD: begin
                            if (r_open) begin
                                if (r_sc_cnt < r_sc_len) begin
                                    stage_we = (32'(r_sc_cnt) < 32'(MAX_PAYLOAD));
                                    n_sc_cnt = r_sc_cnt + 1'b1;
                                end
                                if (i_item.payload_last) begin
                                    n_open  = 1'b0;
                                    n_state = S_FIN;
                                end
                            end
                        end
                        OP_TICK: begin
                            n_tick  = r_tick + 1'b1;
                            n_state = S_TIMER;
                        end
                        OP_READ: begin
                            if (i_item.read_n == '0 || r_fill == '0) begin
                                n_state = S_EMPTY;
                            end else begin
                                n_rd_n  = (r_fill < FILL_W'(i_item.read_n)) ? 6'(r_fill)
                                                                           : i_item.read_n;
                                n_rd_i  = '0;
                                n_state = S_READ_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Judge the closed segment
            S_FIN: begin
                if (!(r_sc_ok && (r_sc_cnt >= r_sc_len))) begin
                    n_state = S_IDLE;
                end else begin
                    if (!r_active) begin
                        n_active = 1'b1;
                        n_prog   = r_tick;
                    end
                    if (end_seq > r_high) n_high = end_seq;
                    if (r_sc_seq < r_exp) begin
                        n_state = S_OLD_ACK;
                    end else if ((r_sc_seq == r_exp)
                                 && (32'(r_sc_len) <= 32'(ring_free))) begin
                        n_copy   = CP_INORDER;
                        n_cp_len = LEN_W'(r_sc_len);
                        n_rd_cnt = '0;
                        n_wr_cnt = '0;
                        n_state  = S_COPY;
                    end else begin
                        n_scan_park = 1'b1;
                        n_idx       = '0;
                        n_free_ok   = 1'b0;
                        n_state     = S_SCAN_RD;
                    end
                end
            end
            S_OLD_ACK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{KIND_ACK, r_exp, 8'd0, 1'b0};
                    n_acked     = r_exp;
                    n_state     = S_IDLE;
                end
            end
            // Resend timer
            S_TIMER: begin
                if (!timer_fire) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{KIND_RESEND, r_exp, 8'd0, 1'b0};
                    n_rseq      = r_exp;
                    n_rtime     = r_tick;
                    n_state     = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{KIND_EMPTY, 32'd0, 8'd0, 1'b0};
                    n_state     = S_IDLE;
                end
            end
            // Drain the ring one byte at a time: read the byte, then emit it once the output is free
            S_READ_RD: begin
                ring_re = 1'b1;
                n_state = S_READ_EMIT;
            end
            S_READ_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{KIND_READ, 32'd0, r_ring_q,
                                    (r_rd_i + 6'd1) == r_rd_n};
                    n_head      = head_inc;
                    n_fill      = r_fill - 1'b1;
                    n_rd_i      = r_rd_i + 6'd1;
                    if ((r_rd_i + 6'd1) == r_rd_n) begin
                        n_moved = 1'b0;
                        n_state = S_MERGE;
                    end else begin
                        n_state = S_READ_RD;
                    end
                end
            end
            S_ACK_CHK: begin
                if (r_acked == r_exp || out_free) begin
                    if (r_acked != r_exp) begin
                        n_out_valid = 1'b1;
                        n_out       = '{KIND_ACK, r_exp, 8'd0, 1'b0};
                        n_acked     = r_exp;
                    end
                    if (r_after_merge) begin
                        n_moved = 1'b0;
                        n_state = S_MERGE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MERGE: begin
                n_scan_park = 1'b0;
                n_idx       = '0;
                n_state     = S_SCAN_RD;
            end
            // Walk the slot table
            S_SCAN_RD: begin
                meta_re = 1'b1;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (r_scan_park) begin
                    if (hit) begin
                        n_state = S_IDLE;
                    end else begin
                        if (!r_valid[r_idx] && !r_free_ok) begin
                            n_free_ok = 1'b1;
                            n_free    = r_idx;
                        end
                        if (last_slot) begin
                            if (n_free_ok) begin
                                n_copy   = CP_PARK;
                                n_cp_len = LEN_W'(r_sc_len);
                                n_rd_cnt = '0;
                                n_wr_cnt = '0;
                                n_state  = S_COPY;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_idx   = r_idx + 1'b1;
                            n_state = S_SCAN_RD;
                        end
                    end
                end else begin
                    if (hit && (32'(r_len_q) <= 32'(ring_free))) begin
                        n_free   = r_idx;
                        n_copy   = CP_MERGE;
                        n_cp_len = r_len_q;
                        n_rd_cnt = '0;
                        n_wr_cnt = '0;
                        n_state  = S_COPY;
                    end else if (hit || last_slot) begin
                        if (r_moved) begin
                            n_prog        = r_tick;
                            n_after_merge = 1'b0;
                            n_state       = S_ACK_CHK;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            // Byte copy: each byte is written in the cycle after it is read
            S_COPY: begin
                if (rd_go) begin
                    stage_re = (r_copy != CP_MERGE);
                    slot_re  = (r_copy == CP_MERGE);
                    n_rd_cnt = r_rd_cnt + 1'b1;
                    n_pv     = 1'b1;
                end
                if (r_pv) begin
                    n_wr_cnt = r_wr_cnt + 1'b1;
                    if (r_copy == CP_PARK) begin
                        slot_we = 1'b1;
                    end else begin
                        ring_we = 1'b1;
                        n_tail  = tail_inc;
                        n_fill  = r_fill + 1'b1;
                    end
                end
                if (cp_done) begin
                    case (r_copy)
                        CP_INORDER: begin
                            n_exp         = r_exp + 32'(r_cp_len);
                            n_prog        = r_tick;
                            n_after_merge = 1'b1;
                            n_state       = S_ACK_CHK;
                        end
                        CP_PARK: begin
                            meta_we         = 1'b1;
                            n_valid[r_free] = 1'b1;
                            n_state         = S_IDLE;
                        end
                        CP_MERGE: begin
                            n_exp           = r_exp + 32'(r_cp_len);
                            n_valid[r_free] = 1'b0;
                            n_moved         = 1'b1;
                            n_state         = S_MERGE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_valid     <= '0;
            r_exp       <= '0;
            r_high      <= '0;
            r_acked     <= '0;
            r_prog      <= '0;
            r_rtime     <= '0;
            r_rseq      <= '0;
            r_tick      <= '0;
            r_active    <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_valid     <= n_valid;
            r_exp       <= n_exp;
            r_high      <= n_high;
            r_acked     <= n_acked;
            r_prog      <= n_prog;
            r_rtime     <= n_rtime;
            r_rseq      <= n_rseq;
            r_tick      <= n_tick;
            r_active    <= n_active;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sc_ok       <= n_sc_ok;
        r_sc_len      <= n_sc_len;
        r_sc_cnt      <= n_sc_cnt;
        r_sc_seq      <= n_sc_seq;
        r_idx         <= n_idx;
        r_free        <= n_free;
        r_free_ok     <= n_free_ok;
        r_moved       <= n_moved;
        r_scan_park   <= n_scan_park;
        r_after_merge <= n_after_merge;
        r_copy        <= n_copy;
        r_cp_len      <= n_cp_len;
        r_rd_cnt      <= n_rd_cnt;
        r_wr_cnt      <= n_wr_cnt;
        r_rd_n        <= n_rd_n;
        r_rd_i        <= n_rd_i;
        r_out         <= n_out;
    end

    // Ring memory
    always_ff @(posedge i_clk) begin
        if (ring_we) r_ring_mem[r_tail] <= wdata;
        if (ring_re) r_ring_q <= r_ring_mem[r_head];
    end

    // Segment staging memory
    always_ff @(posedge i_clk) begin
        if (stage_we) r_stage_mem[r_sc_cnt[OFF_W-1:0]] <= i_item.payload_byte;
        if (stage_re) r_stage_q <= r_stage_mem[r_rd_cnt[OFF_W-1:0]];
    end

    // Slot byte memory
    always_ff @(posedge i_clk) begin
        if (slot_we) r_slot_mem[{r_free, r_wr_cnt[OFF_W-1:0]}] <= r_stage_q;
        if (slot_re) r_slot_q <= r_slot_mem[{r_free, r_rd_cnt[OFF_W-1:0]}];
    end

    // Slot sequence and length memories
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_seq_mem[r_free] <= r_sc_seq;
            r_len_mem[r_free] <= LEN_W'(r_sc_len);
        end
        if (meta_re) begin
            r_seq_q <= r_seq_mem[r_idx];
            r_len_q <= r_len_mem[r_idx];
        end
    end

endmodule
`default_nettype wire

// File: test/reliable_stream_reassembly_test.sv
// Self-checking testbench for the stream reassembly receiver: directed table, floods, random traffic.
`default_nettype none
module reliable_stream_reassembly_test import rsr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RING_SZ   = 65536;
    localparam int unsigned SLOTS     = 64;
    localparam int unsigned MAX_LEN   = 1000;
    localparam int unsigned READ_CAP  = 32;
    localparam int unsigned STALL_MAX = 200000;
    localparam int unsigned SETTLE    = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [79:0] i_s_axis_tdata;
    logic [1:0]  i_s_axis_tuser;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    reliable_stream_reassembly DUT (.*);

    // Receiver-side shadow state
    logic [7:0]  ring_bytes [RING_SZ];
    int unsigned ring_rd, ring_wr, ring_used;
    logic [7:0]  parked_data [SLOTS][MAX_LEN];
    logic        parked_valid [SLOTS];
    logic [31:0] parked_seq [SLOTS];
    int unsigned parked_len [SLOTS];
    logic [31:0] pred_seq, top_end, last_acked;
    logic [31:0] progress_at, resend_at, resend_for, ticks;
    logic        stream_up;
    logic [31:0] timeout_ticks, retry_ticks;
    logic        seg_open;
    logic [7:0]  seg_magic, seg_flags;
    logic [15:0] seg_len;
    logic [31:0] seg_seq;
    int unsigned seg_count;
    logic [7:0]  seg_data [MAX_LEN];

    t_result     expected_results [$];
    t_result     first_of_word;
    logic        word_had_result;

    int unsigned errors, words_sent, results_seen, resends_seen, cyc, idle_cycles;
    int unsigned hold_left;
    logic        hold_req;

    // Directed stimulus table
    typedef struct {
        t_op         op;
        logic [7:0]  magic;
        logic [7:0]  flags;
        logic [15:0] len;
        logic [31:0] seq;
        logic [7:0]  pbyte;
        logic        last;
        logic [5:0]  lim;
        logic        typed;
        t_kind       tkind;
        logic [31:0] tseq;
    } t_row;

    localparam int NROWS = 24;
    t_row rows [NROWS] = '{
        '{OP_READ,    8'h00, 8'h00, 16'd0,    32'd0, 8'h00, 1'b0, 6'd5,  1'b1, KIND_EMPTY, 32'd0},
        '{OP_READ,    8'h00, 8'h00, 16'd0,    32'd0, 8'h00, 1'b0, 6'd0,  1'b1, KIND_EMPTY, 32'd0},
        '{OP_HEADER,  8'h45, 8'h01, 16'd1,    32'd0, 8'h00, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'hFF, 1'b1, 6'd0,  1'b1, KIND_ACK,   32'd1},
        '{OP_HEADER,  8'h00, 8'h01, 16'd1,    32'd1, 8'h00, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'h00, 1'b1, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_HEADER,  8'h45, 8'hFE, 16'd1,    32'd1, 8'h00, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'h11, 1'b1, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_HEADER,  8'h45, 8'h01, 16'd0,    32'd1, 8'h00, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'h22, 1'b1, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_HEADER,  8'h45, 8'h01, 16'd1001, 32'd1, 8'h00, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'h33, 1'b1, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_HEADER,  8'h45, 8'h01, 16'd2,    32'd5, 8'h00, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'hAA, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'h55, 1'b1, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'h77, 1'b1, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_HEADER,  8'h45, 8'h01, 16'd4,    32'd1, 8'h00, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'h01, 1'b1, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_HEADER,  8'hFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 8'h00, 1'b0, 6'd0, 1'b0, KIND_ACK, 32'd0},
        '{OP_HEADER,  8'h45, 8'h01, 16'd4,    32'd1, 8'h00, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'h0F, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'hF0, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'h3C, 1'b0, 6'd0,  1'b0, KIND_ACK,   32'd0},
        '{OP_PAYLOAD, 8'h00, 8'h00, 16'd0,    32'd0, 8'hC3, 1'b1, 6'd0,  1'b1, KIND_ACK,   32'd5}
    };

    function automatic void push_result(t_kind kind, logic [31:0] seq, logic [7:0] b,
                                        logic l);
        t_result r;
        r.kind        = kind;
        r.control_seq = seq;
        r.read_byte   = b;
        r.read_last   = l;
        expected_results.push_back(r);
        if (!word_had_result) begin
            first_of_word   = r;
            word_had_result = 1'b1;
        end
    endfunction

    function automatic int find_parked(logic [31:0] seq);
        for (int i = 0; i < SLOTS; i++)
            if (parked_valid[i] && parked_seq[i] == seq) return i;
        return -1;
    endfunction

    function automatic void park_segment();
        if (find_parked(seg_seq) >= 0) return;
        for (int i = 0; i < SLOTS; i++) begin
            if (!parked_valid[i]) begin
                parked_valid[i] = 1'b1;
                parked_seq[i]   = seg_seq;
                parked_len[i]   = seg_len;
                for (int j = 0; j < seg_len; j++) parked_data[i][j] = seg_data[j];
                return;
            end
        end
    endfunction

    function automatic void ring_push(logic [7:0] b);
        ring_bytes[ring_wr] = b;
        ring_wr = (ring_wr + 1) % RING_SZ;
        ring_used++;
    endfunction

    function automatic void ack_on_change();
        if (last_acked != pred_seq) begin
            push_result(KIND_ACK, pred_seq, 8'h00, 1'b0);
            last_acked = pred_seq;
        end
    endfunction

    // Pull parked slots that now line up with the next sequence into the ring
    function automatic void merge_parked();
        int i;
        logic moved;
        moved = 1'b0;
        while (1) begin
            i = find_parked(pred_seq);
            if (i < 0) break;
            if (parked_len[i] > RING_SZ - ring_used) break;
            for (int j = 0; j < parked_len[i]; j++) ring_push(parked_data[i][j]);
            parked_valid[i] = 1'b0;
            pred_seq = pred_seq + parked_len[i];
            moved = 1'b1;
        end
        if (moved) begin
            progress_at = ticks;
            ack_on_change();
        end
    endfunction

    function automatic void close_segment();
        logic [31:0] seg_end;
        if (seg_magic != SEG_MAGIC || !seg_flags[FLAG_DATA_BIT]) return;
        if (seg_len == 0 || seg_len > MAX_LEN || seg_count < seg_len) return;
        if (!stream_up) begin
            stream_up   = 1'b1;
            progress_at = ticks;
        end
        seg_end = seg_seq + 32'(seg_len);
        if (seg_end > top_end) top_end = seg_end;
        if (seg_seq < pred_seq) begin
            push_result(KIND_ACK, pred_seq, 8'h00, 1'b0);
            last_acked = pred_seq;
        end else if (seg_seq == pred_seq) begin
            if (seg_len > RING_SZ - ring_used) begin
                park_segment();
            end else begin
                for (int j = 0; j < seg_len; j++) ring_push(seg_data[j]);
                pred_seq    = pred_seq + 32'(seg_len);
                progress_at = ticks;
                ack_on_change();
                merge_parked();
            end
        end else begin
            park_segment();
        end
    endfunction

    function automatic void resend_timer_tick();
        ticks++;
        if (!stream_up || top_end <= pred_seq) return;
        if (ticks - progress_at < timeout_ticks) return;
        if (resend_for == pred_seq && ticks - resend_at < retry_ticks) return;
        push_result(KIND_RESEND, pred_seq, 8'h00, 1'b0);
        resend_for = pred_seq;
        resend_at  = ticks;
    endfunction

    function automatic void drain_ring(logic [5:0] lim);
        int unsigned n, want;
        want = (lim > READ_CAP) ? READ_CAP : lim;
        if (want == 0 || ring_used == 0) begin
            push_result(KIND_EMPTY, 32'd0, 8'h00, 1'b0);
            return;
        end
        n = (want < ring_used) ? want : ring_used;
        for (int i = 0; i < n; i++) begin
            push_result(KIND_READ, 32'd0, ring_bytes[ring_rd], i + 1 == n);
            ring_rd = (ring_rd + 1) % RING_SZ;
        end
        ring_used -= n;
        merge_parked();
    endfunction

    function automatic void predict_word(t_op op, logic [7:0] magic, logic [7:0] flags,
                                         logic [15:0] len, logic [31:0] seq,
                                         logic [7:0] b, logic last, logic [5:0] lim);
        word_had_result = 1'b0;
        case (op)
            OP_HEADER: begin
                seg_open  = 1'b1;
                seg_magic = magic;
                seg_flags = flags;
                seg_len   = len;
                seg_seq   = seq;
                seg_count = 0;
            end
            OP_PAYLOAD: begin
                if (seg_open) begin
                    if (seg_count < seg_len) begin
                        if (seg_count < MAX_LEN) seg_data[seg_count] = b;
                        seg_count++;
                    end
                    if (last) begin
                        seg_open = 1'b0;
                        close_segment();
                    end
                end
            end
            OP_TICK: resend_timer_tick();
            default: drain_ring(lim);
        endcase
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Idle-free stretch shared by both sides
    function automatic logic quiet_window();
        return (cyc % 5000) < 1500;
    endfunction

    // Send one word, record its prediction when it is taken
    task automatic send_word(t_op op, logic [7:0] magic, logic [7:0] flags,
                             logic [15:0] len, logic [31:0] seq, logic [7:0] b,
                             logic last, logic [5:0] lim);
        if (!quiet_window() && $urandom_range(0, 99) < 6) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata  = {2'b00, lim, b, seq, len, flags, magic};
        i_s_axis_tuser  = op;
        i_s_axis_tlast  = last;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_word(op, magic, flags, len, seq, b, last, lim);
        words_sent++;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic send_segment(logic [31:0] seq, int unsigned len, int unsigned nbytes,
                                logic [7:0] magic, logic [7:0] flags);
        send_word(OP_HEADER, magic, flags, 16'(len), seq, 8'h00, 1'b0, 6'd0);
        for (int i = 0; i < nbytes; i++)
            send_word(OP_PAYLOAD, 8'h00, 8'h00, 16'd0, 32'd0, 8'($urandom),
                      i + 1 == nbytes, 6'd0);
    endtask

    // Hold until every expected word is back and the block has gone quiet
    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        wait_drained();
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TIMEOUT) timeout_ticks = value;
        else retry_ticks = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_traffic(int unsigned n_words);
        int unsigned start, r, len, nb;
        logic [31:0] seq;
        start = words_sent;
        while (words_sent - start < n_words) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
                                                  : $urandom_range(1, 12);
                r = $urandom_range(0, 99);
                if (r < 60) seq = pred_seq;
                else if (r < 85) seq = pred_seq + len * $urandom_range(1, 3);
                else if (r < 95) seq = pred_seq - $urandom_range(0, 20);
                else seq = $urandom;
                nb = ($urandom_range(0, 9) == 0) ? len + 1 : len;
                send_segment(seq, len, nb, SEG_MAGIC, 8'($urandom) | 8'h01);
            end else if (r < 65) begin
                send_word(OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                          8'($urandom), 1'($urandom), 6'($urandom));
            end else if (r < 80) begin
                send_word(OP_READ, 8'h00, 8'h00, 16'd0, 32'd0, 8'h00, 1'b0,
                          6'($urandom_range(0, 63)));
            end else if (r < 86) begin
                // Malformed header of some kind
                send_segment(pred_seq, $urandom_range(0, 65535), $urandom_range(1, 4),
                             8'($urandom), 8'($urandom));
            end else if (r < 90) begin
                len = $urandom_range(2, 8);
                send_segment(pred_seq, len, $urandom_range(1, len - 1), SEG_MAGIC, 8'h01);
            end else if (r < 94) begin
                // Open a segment and leave it for the next header to abandon
                send_word(OP_HEADER, SEG_MAGIC, 8'h01, 16'd4, pred_seq, 8'h00, 1'b0, 6'd0);
                send_word(OP_PAYLOAD, 8'h00, 8'h00, 16'd0, 32'd0, 8'($urandom), 1'b0, 6'd0);
            end else begin
                send_word(OP_PAYLOAD, 8'($urandom), 8'($urandom), 16'($urandom), $urandom,
                          8'($urandom), 1'($urandom), 6'($urandom));
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = 500;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (quiet_window()) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= 6);
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (t_kind'(o_m_axis_tuser) == KIND_RESEND) resends_seen++;
            if (expected_results.size() == 0) begin
                $error("unexpected result word kind=%0d", o_m_axis_tuser);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tuser != want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tdata[31:0] != want.control_seq) begin
                    $error("control_seq: expected %0h, got %0h", want.control_seq,
                           o_m_axis_tdata[31:0]);
                    errors++;
                end
                if (o_m_axis_tdata[39:32] != want.read_byte) begin
                    $error("read_byte: expected %0h, got %0h", want.read_byte,
                           o_m_axis_tdata[39:32]);
                    errors++;
                end
                if (o_m_axis_tlast != want.read_last) begin
                    $error("read_last: expected %0b, got %0b", want.read_last, o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        cyc++;
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        logic [31:0] base;
        errors = 0; words_sent = 0; results_seen = 0; resends_seen = 0;
        cyc = 0; idle_cycles = 0; hold_left = 0; hold_req = 1'b0;
        ring_rd = 0; ring_wr = 0; ring_used = 0;
        for (int i = 0; i < SLOTS; i++) parked_valid[i] = 1'b0;
        pred_seq = 0; top_end = 0; last_acked = 0;
        progress_at = 0; resend_at = 0; resend_for = 0; ticks = 0; stream_up = 1'b0;
        timeout_ticks = TIMEOUT_RESET; retry_ticks = RETRY_RESET;
        seg_open = 1'b0; seg_count = 0; seg_len = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0; i_s_axis_tdata = '0; i_s_axis_tuser = '0;
        i_s_axis_tlast = 1'b0; i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        for (int k = 0; k < NROWS; k++) begin
            send_word(rows[k].op, rows[k].magic, rows[k].flags, rows[k].len, rows[k].seq,
                      rows[k].pbyte, rows[k].last, rows[k].lim);
            if (rows[k].typed && (!word_had_result || first_of_word.kind != rows[k].tkind ||
                                  first_of_word.control_seq != rows[k].tseq)) begin
                $error("row %0d: expected kind %0d seq %0h from table", k, rows[k].tkind,
                       rows[k].tseq);
                errors++;
            end
        end
        send_word(OP_HEADER, SEG_MAGIC, 8'h01, 16'd1, 32'd0, 8'h00, 1'b0, 6'd0);
        send_word(OP_PAYLOAD, 8'h00, 8'h00, 16'd0, 32'd0, 8'h00, 1'b1, 6'd0);
        send_word(OP_READ, 8'h00, 8'h00, 16'd0, 32'd0, 8'h00, 1'b0, 6'd63);
        send_word(OP_TICK, 8'h00, 8'h00, 16'd0, 32'd0, 8'h00, 1'b0, 6'd0);

        // Fill every slot, overflow it, repeat a held sequence, then close the gap
        base = pred_seq;
        for (int i = 1; i <= SLOTS + 1; i++) send_segment(base + i, 1, 1, SEG_MAGIC, 8'h01);
        send_segment(base + 1, 1, 1, SEG_MAGIC, 8'h01);
        send_segment(base, 1, 1, SEG_MAGIC, 8'h01);
        wait_drained();

        // Fast timer, long receiver hold-off while traffic keeps coming
        write_reg(CFG_TIMEOUT, 32'd1);
        write_reg(CFG_RETRY, 32'd1);
        hold_req = 1'b1;
        send_word(OP_READ, 8'h00, 8'h00, 16'd0, 32'd0, 8'h00, 1'b0, 6'd32);
        random_traffic(20);

        write_reg(CFG_TIMEOUT, 32'hFFFFFFFF);
        write_reg(CFG_RETRY, 32'hFFFFFFFF);
        for (int i = 0; i < 8; i++)
            send_word(OP_TICK, 8'h00, 8'h00, 16'd0, 32'd0, 8'h00, 1'b0, 6'd0);
        send_segment(pred_seq + 3, 2, 2, SEG_MAGIC, 8'h01);
        for (int i = 0; i < 4; i++)
            send_word(OP_TICK, 8'h00, 8'h00, 16'd0, 32'd0, 8'h00, 1'b0, 6'd0);

        write_reg(CFG_TIMEOUT, 32'd3);
        write_reg(CFG_RETRY, 32'd7);
        random_traffic(20);

        wait_drained();
        if (expected_results.size() != 0) begin
            $error("%0d expected result words never arrived", expected_results.size());
            errors++;
        end
        $display("Run covered %0d input words and %0d result words (%0d resend requests),",
                 words_sent, results_seen, resends_seen);
        $display("across four timer settings, slot overflow and a long output hold-off.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
